@@ sv/ust_pkg.sv @@
package ust_pkg;

   // table geometry
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int KEY_W  = 32;
   localparam int MODE_W = 2;

   // beat widths
   localparam int REQ_W = 40;
   localparam int RSP_W = 24;
   localparam int CSR_W = 16;

   // reset value of the capacity register
   localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(DEPTH);

   // operation codes, code 3 behaves as a search
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

@@ sv/unordered_set_table_core.sv @@
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | req_tdata: mode, value
// rsp     | out | rsp_tvalid/tready   | rsp_tdata: found, position, entry_count, is_empty,
//         |     |                     |            insert_dropped
// csr     | in  | csr_valid/ready     | csr_data: capacity
//
// a scan stops at a hit or after the last live entry and an empty table skips it; a remove
// that hits also moves the last entry into the freed slot through ST_MOVE_RD and ST_MOVE_WR;
// req_tready rises in the cycle the result appears.
// the scan reads one entry a cycle through the single read port and one shared comparator.
// reset clears the count and restores capacity to 1024; entries are left unwritten.
// a finished result waits in the output register; a stalled rsp side holds the next
// operation in its last state.
module unordered_set_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [ust_pkg::REQ_W-1:0]    req_tdata,   // mode[1:0], value[33:2], zero pad
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [ust_pkg::RSP_W-1:0]    rsp_tdata,   // found[0], position[10:1],
                                                      // entry_count[21:11], is_empty[22],
                                                      // insert_dropped[23]
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ust_pkg::CSR_W-1:0]    csr_data     // capacity[10:0], zero pad
);

   ust_pkg::state_type state_ff, state_in;

   logic [ust_pkg::MODE_W-1:0]   mode_ff;
   logic [ust_pkg::KEY_W-1:0]    key_ff;
   logic [ust_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ust_pkg::CNT_W-1:0]    capacity_ff;
   logic [ust_pkg::CNT_W-1:0]    issue_ff, issue_in;
   logic                         chk_ff, chk_in;
   logic [ust_pkg::ADDR_W-1:0]   chk_idx_ff, chk_idx_in;
   logic                         hit_ff, hit_in;
   logic [ust_pkg::ADDR_W-1:0]   slot_ff, slot_in;
   logic                         dropped_ff, dropped_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ust_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                         req_acc;
   logic [ust_pkg::CNT_W-1:0]    cap_eff;
   logic [ust_pkg::CNT_W-1:0]    last_cnt;
   logic [ust_pkg::ADDR_W-1:0]   last_idx;
   logic                         scan_end;
   logic                         rsp_room;

   logic                         wr_en;
   logic [ust_pkg::ADDR_W-1:0]   wr_addr;
   logic [ust_pkg::KEY_W-1:0]    wr_data;
   logic [ust_pkg::ADDR_W-1:0]   rd_addr;
   logic [ust_pkg::KEY_W-1:0]    rd_data;
   logic                         match;

   // entry memory and comparator
   ust_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .key     (key_ff),
      .rd_data (rd_data),
      .match   (match)
   );

   // handshakes
   assign req_tready = (state_ff == ust_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_room   = !rsp_valid_ff || rsp_tready;

   // capacity saturated to the table depth
   assign cap_eff = (capacity_ff > ust_pkg::CNT_W'(ust_pkg::DEPTH)) ?
                    ust_pkg::CNT_W'(ust_pkg::DEPTH) : capacity_ff;

   // slot of the last live entry
   assign last_cnt = count_ff - ust_pkg::CNT_W'(1);
   assign last_idx = last_cnt[ust_pkg::ADDR_W-1:0];

   // scan stops on a hit or after comparing the last live entry
   assign scan_end = chk_ff && (match || (chk_idx_ff == last_idx));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ust_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (count_ff == '0) ? ust_pkg::ST_UPDATE : ust_pkg::ST_SCAN;
            end
         end
         ust_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = (mode_ff == ust_pkg::MODE_REMOVE && match) ?
                          ust_pkg::ST_MOVE_RD : ust_pkg::ST_UPDATE;
            end
         end
         ust_pkg::ST_MOVE_RD: state_in = ust_pkg::ST_MOVE_WR;
         ust_pkg::ST_MOVE_WR: state_in = ust_pkg::ST_UPDATE;
         ust_pkg::ST_UPDATE:  state_in = ust_pkg::ST_RESP;
         ust_pkg::ST_RESP: begin
            if (rsp_room) begin
               state_in = ust_pkg::ST_IDLE;
            end
         end
         default: state_in = ust_pkg::ST_IDLE;
      endcase
   end

   // datapath control per state
   always_comb begin
      count_in     = count_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = rd_data;
      rd_addr      = issue_ff[ust_pkg::ADDR_W-1:0];
      case (state_ff)
         ust_pkg::ST_IDLE: begin
            if (req_acc) begin
               issue_in   = '0;
               chk_in     = 1'b0;
               hit_in     = 1'b0;
               slot_in    = '0;
               dropped_in = 1'b0;
            end
         end
         ust_pkg::ST_SCAN: begin
            // issue the next read while comparing the previous one
            if (issue_ff < count_ff) begin
               chk_in     = 1'b1;
               chk_idx_in = issue_ff[ust_pkg::ADDR_W-1:0];
               issue_in   = issue_ff + ust_pkg::CNT_W'(1);
            end else begin
               chk_in = 1'b0;
            end
            if (scan_end) begin
               hit_in  = match;
               slot_in = match ? chk_idx_ff : '0;
            end
         end
         ust_pkg::ST_MOVE_RD: begin
            rd_addr = last_idx;
         end
         ust_pkg::ST_MOVE_WR: begin
            // last entry fills the freed slot
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            count_in = last_cnt;
         end
         ust_pkg::ST_UPDATE: begin
            if (mode_ff == ust_pkg::MODE_INSERT && !hit_ff) begin
               if (count_ff < cap_eff) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[ust_pkg::ADDR_W-1:0];
                  wr_data  = key_ff;
                  count_in = count_ff + ust_pkg::CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end
         ust_pkg::ST_RESP: begin
            if (rsp_room) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {dropped_ff, (count_ff == '0), count_ff, slot_ff, hit_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ust_pkg::ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= ust_pkg::CAPACITY_RESET;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data[ust_pkg::CNT_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         mode_ff <= req_tdata[ust_pkg::MODE_W-1:0];
         key_ff  <= req_tdata[ust_pkg::MODE_W +: ust_pkg::KEY_W];
      end
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      dropped_ff  <= dropped_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sv/ust_store.sv @@
module ust_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ust_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [ust_pkg::KEY_W-1:0]    wr_data,
   input  logic [ust_pkg::ADDR_W-1:0]   rd_addr,
   input  logic [ust_pkg::KEY_W-1:0]    key,
   output logic [ust_pkg::KEY_W-1:0]    rd_data,
   output logic                         match
);

   logic [ust_pkg::KEY_W-1:0] mem [ust_pkg::DEPTH];
   logic [ust_pkg::KEY_W-1:0] rd_data_ff;

   // entry storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // shared key comparator on the read data
   assign rd_data = rd_data_ff;
   assign match   = (rd_data_ff == key);

endmodule

@@ sv/ust_checker.sv @@
module ust_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [ust_pkg::RSP_W-1:0]    rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one operation at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an operation is in flight");

   // empty flag agrees with the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22] == (rsp_tdata[21:11] == '0)))
      else $error("is_empty disagrees with entry_count");

   // count never beyond the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:11] <= ust_pkg::CNT_W'(ust_pkg::DEPTH)))
      else $error("entry_count beyond table depth");

   // a miss reports slot zero
   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata[10:1] == '0))
      else $error("position set on a miss");

endmodule

bind unordered_set_table_core ust_checker u_ust_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ dv/unordered_set_table_checker.sv @@
module unordered_set_table_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [ust_pkg::REQ_W-1:0]  req_tdata,    // mode[1:0], value[33:2], zero pad
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [ust_pkg::RSP_W-1:0]  rsp_tdata,    // found[0], position[10:1],
                                                    // entry_count[21:11], is_empty[22],
                                                    // insert_dropped[23]
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [ust_pkg::CSR_W-1:0]  csr_data,     // capacity[10:0], zero pad
   output int                         fail_count,
   output int                         pending
);

   typedef struct {
      logic                       found;
      logic [ust_pkg::ADDR_W-1:0] position;
      logic [ust_pkg::CNT_W-1:0]  entry_count;
      logic                       is_empty;
      logic                       insert_dropped;
   } set_reply_type;

   // shadow copy of the table
   logic [ust_pkg::KEY_W-1:0] members [ust_pkg::DEPTH];
   int unsigned               member_count;
   logic [ust_pkg::CNT_W-1:0] capacity;
   set_reply_type             reply_q [$];

   // one operation on the shadow table, returns the reply it should give
   function automatic set_reply_type apply_op(input logic [ust_pkg::MODE_W-1:0] mode,
                                              input logic [ust_pkg::KEY_W-1:0]  key);
      set_reply_type r;
      int unsigned   room;
      int unsigned   slot;
      int unsigned   i;
      bit            hit;
      room = (capacity > ust_pkg::DEPTH) ? ust_pkg::DEPTH : capacity;
      hit  = 1'b0;
      slot = 0;
      i    = 0;
      // linear scan over the live entries, first hit wins
      while (i < member_count && !hit) begin
         if (members[i] == key) begin
            hit  = 1'b1;
            slot = i;
         end
         i++;
      end
      r.insert_dropped = 1'b0;
      if (mode == ust_pkg::MODE_INSERT && !hit) begin
         if (member_count < room) begin
            members[member_count] = key;
            member_count++;
         end else begin
            r.insert_dropped = 1'b1;
         end
      end else if (mode == ust_pkg::MODE_REMOVE && hit) begin
         // last live entry fills the freed slot
         members[slot] = members[member_count-1];
         member_count--;
      end
      r.found       = hit;
      r.position    = ust_pkg::ADDR_W'(slot);
      r.entry_count = ust_pkg::CNT_W'(member_count);
      r.is_empty    = (member_count == 0);
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t reply field %s: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // watch the three channels on every rising edge
   always @(posedge clock) begin
      set_reply_type want;
      set_reply_type got;
      if (reset) begin
         member_count = 0;
         capacity     = ust_pkg::CAPACITY_RESET;
         reply_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            capacity = csr_data[ust_pkg::CNT_W-1:0];
         // result beat against the oldest awaited reply
         if (rsp_tvalid && rsp_tready) begin
            got.found          = rsp_tdata[0];
            got.position       = rsp_tdata[10:1];
            got.entry_count    = rsp_tdata[21:11];
            got.is_empty       = rsp_tdata[22];
            got.insert_dropped = rsp_tdata[23];
            if (reply_q.size() == 0) begin
               $display("%0t reply beat: expected none, actual found=%0d position=%0d",
                        $time, got.found, got.position);
               $display("   count=%0d empty=%0d dropped=%0d",
                        got.entry_count, got.is_empty, got.insert_dropped);
               fail_count++;
            end else begin
               want = reply_q.pop_front();
               check_field("found", want.found, got.found);
               check_field("position", want.position, got.position);
               check_field("entry_count", want.entry_count, got.entry_count);
               check_field("is_empty", want.is_empty, got.is_empty);
               check_field("insert_dropped", want.insert_dropped, got.insert_dropped);
            end
         end
         if (req_tvalid && req_tready)
            reply_q.push_back(apply_op(req_tdata[ust_pkg::MODE_W-1:0],
                                       req_tdata[ust_pkg::MODE_W +: ust_pkg::KEY_W]));
      end
      pending = reply_q.size();
   end

endmodule

@@ dv/testbench.sv @@
module testbench;

   localparam logic [ust_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int POOL_DEPTH  = 256;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic [ust_pkg::REQ_W-1:0] req_tdata  = '0;
   logic                      rsp_tready = 1'b0;
   logic                      csr_valid  = 1'b0;
   logic [ust_pkg::CSR_W-1:0] csr_data   = '0;
   logic                      req_tready;
   logic                      rsp_tvalid;
   logic [ust_pkg::RSP_W-1:0] rsp_tdata;
   logic                      csr_ready;
   int                        fail_count;
   int                        pending;
   int                        idle_cycles = 0;
   bit                        calm        = 1'b0;
   bit                        hold_rsp    = 1'b0;
   logic [ust_pkg::KEY_W-1:0] key_pool [POOL_DEPTH];
   int                        pool_size   = 0;

   always #6 clock = ~clock;

   unordered_set_table_core u_dut (.*);

   unordered_set_table_checker u_checker (.*);

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("unordered_set_table_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin : result_sink
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(1, 17);
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   // offer one beat and hold it until taken; tvalid stays high afterwards
   task automatic push_op(input logic [ust_pkg::MODE_W-1:0] mode,
                          input logic [ust_pkg::KEY_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, value, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   // same, with a random gap in front
   task automatic issue(input logic [ust_pkg::MODE_W-1:0] mode,
                        input logic [ust_pkg::KEY_W-1:0] value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      push_op(mode, value);
   endtask

   // stop offering and wait for every awaited reply
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned cap);
      drain();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ust_pkg::CSR_W'(cap);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly keys from the pool so that hits and duplicates are common
   function automatic logic [ust_pkg::KEY_W-1:0] pick_key();
      if (pool_size > 0 && $urandom_range(0, 9) < 8)
         return key_pool[$urandom_range(0, pool_size - 1)];
      return $urandom;
   endfunction

   task automatic run_phase(input int unsigned cap, input int items, input int keys,
                            input int insert_pct);
      int                         r;
      logic [ust_pkg::MODE_W-1:0] mode;
      write_capacity(cap);
      pool_size = keys;
      for (int n = 0; n < items; n++) begin
         r = $urandom_range(0, 99);
         if (r < insert_pct)
            mode = ust_pkg::MODE_INSERT;
         else if (r < insert_pct + (100 - insert_pct) / 2)
            mode = ust_pkg::MODE_REMOVE;
         else if (r < 96)
            mode = ust_pkg::MODE_SEARCH;
         else
            mode = MODE_UNUSED;
         issue(mode, pick_key());
      end
   endtask

   initial begin
      // key pool with the extremes at the front
      for (int i = 0; i < POOL_DEPTH; i++)
         key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, unused code
      issue(ust_pkg::MODE_SEARCH, 32'h0000_0000);
      issue(ust_pkg::MODE_REMOVE, 32'h0000_0005);
      issue(MODE_UNUSED, 32'h0000_0007);
      // extremes, duplicate insert, remove with move of the last entry
      issue(ust_pkg::MODE_INSERT, 32'h8000_0000);
      issue(ust_pkg::MODE_INSERT, 32'h7FFF_FFFF);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0000);
      issue(ust_pkg::MODE_INSERT, 32'hFFFF_FFFF);
      issue(ust_pkg::MODE_INSERT, 32'h7FFF_FFFF);
      issue(ust_pkg::MODE_SEARCH, 32'hFFFF_FFFF);
      issue(MODE_UNUSED, 32'h8000_0000);
      issue(ust_pkg::MODE_REMOVE, 32'h8000_0000);
      issue(ust_pkg::MODE_SEARCH, 32'hFFFF_FFFF);
      issue(ust_pkg::MODE_REMOVE, 32'h0000_0005);
      // full table
      write_capacity(3);
      issue(ust_pkg::MODE_INSERT, 32'h0000_3039);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0000);
      // capacity below the count
      write_capacity(2);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0007);
      issue(ust_pkg::MODE_REMOVE, 32'h0000_0000);
      issue(ust_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0007);
      // zero capacity
      write_capacity(0);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0009);
      issue(ust_pkg::MODE_SEARCH, 32'h0000_0007);
      // capacity above the table size saturates
      write_capacity(2047);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0009);
      // single slot, emptied and refilled
      write_capacity(1);
      issue(ust_pkg::MODE_INSERT, 32'h0000_000A);
      issue(ust_pkg::MODE_REMOVE, 32'h7FFF_FFFF);
      issue(ust_pkg::MODE_REMOVE, 32'h0000_0007);
      issue(ust_pkg::MODE_REMOVE, 32'h0000_0009);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0001);
      issue(ust_pkg::MODE_INSERT, 32'h0000_0002);

      // random phases over several capacities
      run_phase(16, 60, 24, 50);
      run_phase(1024, 160, 256, 65);

      // long result hold-off while requests keep coming, so the input stalls
      hold_rsp = 1'b1;
      pool_size = 64;
      for (int n = 0; n < 8; n++)
         push_op(ust_pkg::MODE_SEARCH, pick_key());
      drain();

      run_phase(5, 60, 40, 25);
      run_phase(0, 30, 24, 50);
      run_phase(2047, 70, 64, 50);
      run_phase(1, 40, 8, 40);
      run_phase(3, 40, 8, 50);

      // closing stretch without idling
      calm = 1'b1;
      run_phase(1024, 80, 32, 45);

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("unordered_set_table_core: match");
      else
         $display("unordered_set_table_core: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
sv/ust_pkg.sv
sv/ust_store.sv
sv/unordered_set_table_core.sv
sv/ust_checker.sv
dv/unordered_set_table_checker.sv
dv/testbench.sv
